FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, quiet while rst_n is low.
`define CIA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that sig keeps its value at the edge after one where hold was high.
`define CIA_ASSERT_HELD(lbl, hold, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ($past(hold) |-> $stable(sig))) else $error(msg);

`endif

FILE: rtl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and constants of the checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int DATA_WIDTH = 32;

    localparam logic [7:0] OP_ADD = 8'd43;
    localparam logic [7:0] OP_SUB = 8'd45;
    localparam logic [7:0] OP_MUL = 8'd120;
    localparam logic [7:0] OP_DIV = 8'd47;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_OVER    = 3'd1,
        ST_UNDER   = 3'd2,
        ST_DIVZERO = 3'd3,
        ST_BADOP   = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]                   action;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic [2:0]                   status;
    } rsp_t;

endpackage

FILE: rtl/cia_div.sv
// ----------------------------------------------------------------------------
// cia_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cia_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic [cia_pkg::DATA_WIDTH-1:0] dividend,
    input  logic [cia_pkg::DATA_WIDTH-1:0] divisor,
    output logic [cia_pkg::DATA_WIDTH-1:0] quotient
);
    localparam int W = cia_pkg::DATA_WIDTH;

    logic [W-1:0] rem_reg [W];
    logic [W-1:0] dvd_reg [W];
    logic [W-1:0] dvs_reg [W];

    for (genvar i = 0; i < W; i++) begin : g_stage
        logic [W-1:0] rem_prev;
        logic [W-1:0] dvd_prev;
        logic [W-1:0] dvs_prev;
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic [W-1:0] rem_next;
        logic [W-1:0] dvd_next;

        if (i == 0) begin : g_first
            assign rem_prev = '0;
            assign dvd_prev = dividend;
            assign dvs_prev = divisor;
        end else begin : g_rest
            assign rem_prev = rem_reg[i-1];
            assign dvd_prev = dvd_reg[i-1];
            assign dvs_prev = dvs_reg[i-1];
        end

        always_comb
        begin
            trial = {rem_prev, dvd_prev[W-1]};
            diff  = trial - {1'b0, dvs_prev};
            if (!diff[W])
            begin
                rem_next = diff[W-1:0];
                dvd_next = {dvd_prev[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                dvd_next = {dvd_prev[W-2:0], 1'b0};
            end
        end

        // payload only; valid travels in the top level
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                dvd_reg[i] <= dvd_next;
                dvs_reg[i] <= dvs_prev;
            end
        end
    end

    assign quotient = dvd_reg[W-1];

    `include "assert_macros.svh"
    `CIA_ASSERT(a_div_rem_small, !en || (rem_reg[0] <= {W{1'b1}}), "divider remainder broken")
    `CIA_ASSERT_HELD(a_div_stable, !en, quotient, "divider moved while held")
    `CIA_ASSERT(a_div_dvs_pass, !$past(en) || (dvs_reg[1] == $past(dvs_reg[0])), "divisor lost")

endmodule

FILE: rtl/checked_integer_alu_core.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_core
// Signed add, subtract, multiply and divide with overflow and error status.
// ----------------------------------------------------------------------------
// One beat in, one beat out, in order. A new request is taken every cycle
// while the response side keeps taking beats. The pipe is an input
// register, an operand stage that does the add, subtract and 32x32
// multiply, DATA_WIDTH divider stages of one quotient bit each, and the
// response register. The whole pipe holds when a response beat sits
// stalled. Any error status returns a zero result; dividing the most
// negative value by minus one reports overflow.
module checked_integer_alu_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cia_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cia_pkg::rsp_t  rsp
);
    localparam int W = cia_pkg::DATA_WIDTH;

    typedef struct packed {
        logic         is_div;
        logic         neg;
        logic [2:0]   status;
        logic [W-1:0] result;
    } side_t;

    logic adv;

    // Advance everything unless the response register holds an untaken beat.
    assign adv       = !(rsp_valid && rsp_stall);
    assign req_stall = !adv;

    // ---- stage 1: capture the request
    logic         s1_valid_reg;
    cia_pkg::req_t s1_req_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s1_req_reg <= req;
    end

    // ---- stage 2: add/subtract, multiply, divider operands
    logic signed [W:0]     sum_next;
    logic signed [W:0]     dif_next;
    logic signed [2*W-1:0] prod_next;
    logic [W-1:0]          abs_a_next;
    logic [W-1:0]          abs_b_next;

    always_comb
    begin
        sum_next   = {s1_req_reg.operand_a[W-1], s1_req_reg.operand_a}
                   + {s1_req_reg.operand_b[W-1], s1_req_reg.operand_b};
        dif_next   = {s1_req_reg.operand_a[W-1], s1_req_reg.operand_a}
                   - {s1_req_reg.operand_b[W-1], s1_req_reg.operand_b};
        prod_next  = s1_req_reg.operand_a * s1_req_reg.operand_b;
        abs_a_next = s1_req_reg.operand_a[W-1] ? W'(-s1_req_reg.operand_a)
                                               : s1_req_reg.operand_a;
        abs_b_next = s1_req_reg.operand_b[W-1] ? W'(-s1_req_reg.operand_b)
                                               : s1_req_reg.operand_b;
    end

    logic                  s2_valid_reg;
    logic [7:0]            s2_op_reg;
    logic signed [W:0]     s2_sum_reg;
    logic signed [W:0]     s2_dif_reg;
    logic signed [2*W-1:0] s2_prod_reg;
    logic [W-1:0]          s2_abs_a_reg;
    logic [W-1:0]          s2_abs_b_reg;
    logic                  s2_neg_reg;
    logic                  s2_bzero_reg;
    logic                  s2_mindiv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg     <= s1_req_reg.action;
            s2_sum_reg    <= sum_next;
            s2_dif_reg    <= dif_next;
            s2_prod_reg   <= prod_next;
            s2_abs_a_reg  <= abs_a_next;
            s2_abs_b_reg  <= abs_b_next;
            s2_neg_reg    <= s1_req_reg.operand_a[W-1] ^ s1_req_reg.operand_b[W-1];
            s2_bzero_reg  <= (s1_req_reg.operand_b == '0);
            s2_mindiv_reg <= (s1_req_reg.operand_a == {1'b1, {(W-1){1'b0}}})
                          && (s1_req_reg.operand_b == '1);
        end
    end

    // ---- stage 3: settle status; divider runs alongside the side line
    side_t side_next;
    logic  prod_hi_zero;
    logic  prod_hi_ones;

    always_comb
    begin
        prod_hi_zero     = (s2_prod_reg[2*W-1:W-1] == '0);
        prod_hi_ones     = (s2_prod_reg[2*W-1:W-1] == '1);
        side_next.is_div = 1'b0;
        side_next.neg    = s2_neg_reg;
        side_next.status = cia_pkg::ST_OK;
        side_next.result = '0;
        case (s2_op_reg)
            cia_pkg::OP_ADD:
            begin
                if (s2_sum_reg[W] != s2_sum_reg[W-1])
                    side_next.status = s2_sum_reg[W] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
                else
                    side_next.result = s2_sum_reg[W-1:0];
            end
            cia_pkg::OP_SUB:
            begin
                if (s2_dif_reg[W] != s2_dif_reg[W-1])
                    side_next.status = s2_dif_reg[W] ? cia_pkg::ST_UNDER : cia_pkg::ST_OVER;
                else
                    side_next.result = s2_dif_reg[W-1:0];
            end
            cia_pkg::OP_MUL:
            begin
                if (!s2_prod_reg[2*W-1] && !prod_hi_zero)
                    side_next.status = cia_pkg::ST_OVER;
                else if (s2_prod_reg[2*W-1] && !prod_hi_ones)
                    side_next.status = cia_pkg::ST_UNDER;
                else
                    side_next.result = s2_prod_reg[W-1:0];
            end
            cia_pkg::OP_DIV:
            begin
                side_next.is_div = 1'b1;
                if (s2_bzero_reg)
                    side_next.status = cia_pkg::ST_DIVZERO;
                else if (s2_mindiv_reg)
                    side_next.status = cia_pkg::ST_OVER;
            end
            default:
                side_next.status = cia_pkg::ST_BADOP;
        endcase
    end

    logic         side_valid_reg [W];
    side_t        side_reg [W];
    logic [W-1:0] quotient;

    for (genvar i = 0; i < W; i++) begin : g_side
        logic  valid_prev;
        side_t side_prev;

        if (i == 0) begin : g_first
            assign valid_prev = s2_valid_reg;
            assign side_prev  = side_next;
        end else begin : g_rest
            assign valid_prev = side_valid_reg[i-1];
            assign side_prev  = side_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_valid_reg[i] <= 1'b0;
            else if (adv)
                side_valid_reg[i] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[i] <= side_prev;
        end
    end

    cia_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .dividend (s2_abs_a_reg),
        .divisor  (s2_abs_b_reg),
        .quotient (quotient)
    );

    // ---- response register: apply the quotient sign, zero on error
    side_t   tail;
    logic    tail_valid;
    cia_pkg::rsp_t rsp_next;

    always_comb
    begin
        tail            = side_reg[W-1];
        tail_valid      = side_valid_reg[W-1];
        rsp_next.status = tail.status;
        rsp_next.result = tail.result;
        if (tail.is_div && (tail.status == cia_pkg::ST_OK))
            rsp_next.result = tail.neg ? W'(-quotient) : quotient;
    end

    logic          rsp_valid_reg;
    cia_pkg::rsp_t rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (adv)
            rsp_valid_reg <= tail_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `include "assert_macros.svh"
    `CIA_ASSERT(a_err_zero, !rsp_valid || (rsp.status == cia_pkg::ST_OK) || (rsp.result == '0), "error beat nonzero")
    `CIA_ASSERT(a_divzero_is_div, !tail_valid || (tail.status != cia_pkg::ST_DIVZERO) || tail.is_div, "bad divzero")
    `CIA_ASSERT_HELD(a_hold_tail, rsp_valid && rsp_stall, side_reg[W-1], "pipe moved while held")

endmodule

FILE: test/checked_integer_alu_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// checked_integer_alu_core_test
// Drives request beats through the checked ALU core under random idling on
// both sides and compares each response beat with a local prediction.
// ----------------------------------------------------------------------------
module checked_integer_alu_core_test;

    localparam int LATENCY   = cia_pkg::DATA_WIDTH + 3;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 700;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    cia_pkg::req_t  req = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b1;
    cia_pkg::rsp_t  rsp;

    cia_pkg::rsp_t  expected_rsps[$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    sink_idling = 1'b1;   // random idling of the response side
    bit    sink_hold = 1'b0;     // long hold-off of the response side
    int    src_idle_pct = 38;

    checked_integer_alu_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // Compute the checked result of one request, using 64-bit arithmetic.
    function automatic cia_pkg::rsp_t alu_predict(cia_pkg::req_t r);
        longint a;
        longint b;
        longint hi;
        longint lo;
        longint v;
        cia_pkg::status_t st;
        cia_pkg::rsp_t o;
        a  = longint'(r.operand_a);
        b  = longint'(r.operand_b);
        hi = (longint'(1) <<< (cia_pkg::DATA_WIDTH - 1)) - 1;
        lo = -hi - 1;
        v  = 0;
        st = cia_pkg::ST_OK;
        case (r.action)
            cia_pkg::OP_ADD: v = a + b;
            cia_pkg::OP_SUB: v = a - b;
            cia_pkg::OP_MUL: v = a * b;
            cia_pkg::OP_DIV:
            begin
                if (b == 0)
                    st = cia_pkg::ST_DIVZERO;
                else
                    v = a / b;
            end
            default: st = cia_pkg::ST_BADOP;
        endcase
        // Range check covers add, sub, mul and the lo / -1 division.
        if (st == cia_pkg::ST_OK && v > hi)
            st = cia_pkg::ST_OVER;
        else if (st == cia_pkg::ST_OK && v < lo)
            st = cia_pkg::ST_UNDER;
        if (st != cia_pkg::ST_OK)
            v = 0;
        o.result = v[cia_pkg::DATA_WIDTH-1:0];
        o.status = st;
        return o;
    endfunction

    // Drive one request beat at the falling edge and hold it until taken.
    task automatic send_beat(logic [7:0] act, logic [31:0] a, logic [31:0] b);
        cia_pkg::req_t r;
        r.action    = act;
        r.operand_a = a;
        r.operand_b = b;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsps.push_back(alu_predict(r));
        @(negedge clk);
    endtask

    // Pick an operand with a bias toward edges of the range.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(4)) - 2);
            3: return $urandom_range(65535);
            4: return -$urandom_range(65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_action();
        case ($urandom_range(9))
            0, 1: return cia_pkg::OP_ADD;
            2, 3: return cia_pkg::OP_SUB;
            4, 5: return cia_pkg::OP_MUL;
            6, 7: return cia_pkg::OP_DIV;
            default: return 8'($urandom);
        endcase
    endfunction

    // Drop the request valid, wait for every expected response, then let the
    // pipe drain.
    task automatic drain_all();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_directed();
        send_beat(cia_pkg::OP_ADD, 32'h7fff_ffff, 32'd1);
        send_beat(cia_pkg::OP_ADD, 32'h8000_0000, 32'hffff_ffff);
        send_beat(cia_pkg::OP_ADD, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(cia_pkg::OP_SUB, 32'h8000_0000, 32'd1);
        send_beat(cia_pkg::OP_SUB, 32'h7fff_ffff, 32'hffff_ffff);
        send_beat(cia_pkg::OP_SUB, 32'd0, 32'h8000_0000);
        send_beat(cia_pkg::OP_SUB, 32'hffff_ffff, 32'h8000_0000);
        send_beat(cia_pkg::OP_MUL, 32'h0001_0000, 32'h0000_8000);
        send_beat(cia_pkg::OP_MUL, 32'h0001_0000, 32'hffff_8000);
        send_beat(cia_pkg::OP_MUL, 32'h0001_0000, 32'hffff_7fff);
        send_beat(cia_pkg::OP_MUL, 32'h8000_0000, 32'hffff_ffff);
        send_beat(cia_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_beat(cia_pkg::OP_MUL, 32'h8000_0000, 32'd1);
        send_beat(cia_pkg::OP_DIV, 32'd7, 32'd0);
        send_beat(cia_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_beat(cia_pkg::OP_DIV, 32'hffff_fff9, 32'd2);
        send_beat(cia_pkg::OP_DIV, 32'd7, 32'hffff_fffe);
        send_beat(cia_pkg::OP_DIV, 32'h8000_0000, 32'd1);
        send_beat(cia_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000);
        send_beat(8'h00, 32'd1, 32'd1);
        send_beat(8'hff, 32'hffff_ffff, 32'hffff_ffff);
        send_beat(8'd44, 32'd3, 32'd4);
        drain_all();
    endtask

    task automatic test_random();
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Run a stretch with no idling on either side.
            if (i == 300)
            begin
                src_idle_pct = 0;
                sink_idling  = 1'b0;
            end
            if (i == 400)
            begin
                src_idle_pct = 38;
                sink_idling  = 1'b1;
            end
            send_beat(pick_action(), pick_operand(), pick_operand());
        end
        drain_all();
    endtask

    // Hold off the response side while beats keep coming, so the pipe fills.
    task automatic test_backpressure();
        fork
            begin
                sink_hold = 1'b1;
                repeat (LATENCY * 3) @(posedge clk);
                sink_hold = 1'b0;
            end
        join_none
        src_idle_pct = 0;
        for (int i = 0; i < 2 * LATENCY; i++)
            send_beat(pick_action(), pick_operand(), pick_operand());
        src_idle_pct = 38;
        // Pause the source until every result is back.
        drain_all();
        for (int i = 0; i < 20; i++)
            send_beat(pick_action(), pick_operand(), pick_operand());
        drain_all();
    endtask

    // Drive the response stall at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
            rsp_stall <= sink_hold || (sink_idling && $urandom_range(99) < 38);
    end

    // Check each accepted response beat against the oldest prediction.
    always @(posedge clk)
    begin
        cia_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: result %0d status %0d",
                             rsp.result, rsp.status);
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.result !== want.result || rsp.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d/%0d actual %0d/%0d",
                                 want.result, want.status, rsp.result, rsp.status);
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted beat on either side.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
